// File: src/qrm_pkg.sv
// Shared types and constants of the quaternion to rotation matrix pipeline.
// Used by every module of the block; depends on nothing.
`default_nettype none

package qrm_pkg;

  localparam int SampleWidth  = 16;
  localparam int ProdWidth    = 2 * SampleWidth;
  localparam int DiagSumWidth = 2 * SampleWidth + 2;
  localparam int OffSumWidth  = 2 * SampleWidth + 1;

  typedef logic signed [SampleWidth-1:0]  sample_t;
  typedef logic signed [ProdWidth-1:0]    prod_t;
  typedef logic signed [DiagSumWidth-1:0] diag_sum_t;
  typedef logic signed [OffSumWidth-1:0]  off_sum_t;

  // Half an output LSB at each scale, so that a floor gives round to nearest.
  localparam diag_sum_t DiagBias = diag_sum_t'(1) <<< (SampleWidth - 2);
  localparam off_sum_t  OffBias  = off_sum_t'(1) <<< (SampleWidth - 3);

  typedef struct packed {
    sample_t e0;
    sample_t ex;
    sample_t ey;
    sample_t ez;
  } quat_t;

  typedef struct packed {
    prod_t e02;
    prod_t ex2;
    prod_t ey2;
    prod_t ez2;
    prod_t e0ez;
    prod_t exey;
    prod_t exez;
    prod_t e0ey;
    prod_t e0ex;
    prod_t eyez;
  } prod_set_t;

  typedef struct packed {
    diag_sum_t xx;
    off_sum_t  xy;
    off_sum_t  xz;
    off_sum_t  yx;
    diag_sum_t yy;
    off_sum_t  yz;
    off_sum_t  zx;
    off_sum_t  zy;
    diag_sum_t zz;
  } sum_set_t;

  typedef struct packed {
    sample_t xx;
    sample_t xy;
    sample_t xz;
    sample_t yx;
    sample_t yy;
    sample_t yz;
    sample_t zx;
    sample_t zy;
    sample_t zz;
  } mat_t;

endpackage

`default_nettype wire

// File: src/qrm_mult.sv
// Product stage: the ten exact products of the quaternion components.
// Depends on qrm_pkg.
`default_nettype none

module qrm_mult (
  input  wire               clk_i,
  input  wire               en_i,
  input  qrm_pkg::quat_t     quat_i,
  output qrm_pkg::prod_set_t prod_o
);
  import qrm_pkg::*;

  prod_set_t prod_d, prod_q;
  prod_t     e0, ex, ey, ez;

  assign e0 = prod_t'(quat_i.e0);
  assign ex = prod_t'(quat_i.ex);
  assign ey = prod_t'(quat_i.ey);
  assign ez = prod_t'(quat_i.ez);

  always_comb begin
    prod_d.e02  = e0 * e0;
    prod_d.ex2  = ex * ex;
    prod_d.ey2  = ey * ey;
    prod_d.ez2  = ez * ez;
    prod_d.e0ez = e0 * ez;
    prod_d.exey = ex * ey;
    prod_d.exez = ex * ez;
    prod_d.e0ey = e0 * ey;
    prod_d.e0ex = e0 * ex;
    prod_d.eyez = ey * ez;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule

`default_nettype wire

// File: src/qrm_sum.sv
// Sum stage: the nine exact element sums, each with its rounding bias added.
// Depends on qrm_pkg.
`default_nettype none

module qrm_sum (
  input  wire               clk_i,
  input  wire               en_i,
  input  qrm_pkg::prod_set_t prod_i,
  output qrm_pkg::sum_set_t  sum_o
);
  import qrm_pkg::*;

  sum_set_t  sum_d, sum_q;
  diag_sum_t d_e02, d_ex2, d_ey2, d_ez2;
  off_sum_t  o_e0ez, o_exey, o_exez, o_e0ey, o_e0ex, o_eyez;

  assign d_e02  = diag_sum_t'(prod_i.e02);
  assign d_ex2  = diag_sum_t'(prod_i.ex2);
  assign d_ey2  = diag_sum_t'(prod_i.ey2);
  assign d_ez2  = diag_sum_t'(prod_i.ez2);
  assign o_e0ez = off_sum_t'(prod_i.e0ez);
  assign o_exey = off_sum_t'(prod_i.exey);
  assign o_exez = off_sum_t'(prod_i.exez);
  assign o_e0ey = off_sum_t'(prod_i.e0ey);
  assign o_e0ex = off_sum_t'(prod_i.e0ex);
  assign o_eyez = off_sum_t'(prod_i.eyez);

  always_comb begin
    sum_d.xx = d_e02 + d_ex2 - d_ey2 - d_ez2 + DiagBias;
    sum_d.yy = d_e02 - d_ex2 + d_ey2 - d_ez2 + DiagBias;
    sum_d.zz = d_e02 - d_ex2 - d_ey2 + d_ez2 + DiagBias;
    sum_d.xy = o_e0ez + o_exey + OffBias;
    sum_d.xz = o_exez - o_e0ey + OffBias;
    sum_d.yx = o_exey - o_e0ez + OffBias;
    sum_d.yz = o_e0ex + o_eyez + OffBias;
    sum_d.zx = o_e0ey + o_exez + OffBias;
    sum_d.zy = o_eyez - o_e0ex + OffBias;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sum_q <= sum_d;
    end
  end

  assign sum_o = sum_q;

endmodule

`default_nettype wire

// File: src/qrm_round.sv
// Output stage: scales each biased sum to Q1.15, saturates it and flags clipping.
// Depends on qrm_pkg.
`default_nettype none

module qrm_round (
  input  wire              clk_i,
  input  wire              en_i,
  input  qrm_pkg::sum_set_t sum_i,
  output qrm_pkg::mat_t     mat_o,
  output logic             clipped_o
);
  import qrm_pkg::*;

  localparam logic [SampleWidth-1:0] MaxVal = {1'b0, {(SampleWidth-1){1'b1}}};
  localparam logic [SampleWidth-1:0] MinVal = {1'b1, {(SampleWidth-1){1'b0}}};

  // The result carries the clip flag in its top bit.
  function automatic logic [SampleWidth:0] sat_diag(input diag_sum_t s);
    logic [DiagSumWidth-2*SampleWidth+1:0] top;
    logic [SampleWidth:0]                  res;
    top = s[DiagSumWidth-1:2*SampleWidth-2];
    if ((&top) || !(|top)) begin
      res = {1'b0, s[2*SampleWidth-2:SampleWidth-1]};
    end else if (s[DiagSumWidth-1]) begin
      res = {1'b1, MinVal};
    end else begin
      res = {1'b1, MaxVal};
    end
    return res;
  endfunction

  function automatic logic [SampleWidth:0] sat_off(input off_sum_t s);
    logic [OffSumWidth-2*SampleWidth+2:0] top;
    logic [SampleWidth:0]                 res;
    top = s[OffSumWidth-1:2*SampleWidth-3];
    if ((&top) || !(|top)) begin
      res = {1'b0, s[2*SampleWidth-3:SampleWidth-2]};
    end else if (s[OffSumWidth-1]) begin
      res = {1'b1, MinVal};
    end else begin
      res = {1'b1, MaxVal};
    end
    return res;
  endfunction

  logic [SampleWidth:0] r_xx, r_xy, r_xz, r_yx, r_yy, r_yz, r_zx, r_zy, r_zz;
  mat_t                 mat_d, mat_q;
  logic                 clip_d, clip_q;

  always_comb begin
    r_xx = sat_diag(sum_i.xx);
    r_yy = sat_diag(sum_i.yy);
    r_zz = sat_diag(sum_i.zz);
    r_xy = sat_off(sum_i.xy);
    r_xz = sat_off(sum_i.xz);
    r_yx = sat_off(sum_i.yx);
    r_yz = sat_off(sum_i.yz);
    r_zx = sat_off(sum_i.zx);
    r_zy = sat_off(sum_i.zy);
    mat_d.xx = sample_t'(r_xx[SampleWidth-1:0]);
    mat_d.xy = sample_t'(r_xy[SampleWidth-1:0]);
    mat_d.xz = sample_t'(r_xz[SampleWidth-1:0]);
    mat_d.yx = sample_t'(r_yx[SampleWidth-1:0]);
    mat_d.yy = sample_t'(r_yy[SampleWidth-1:0]);
    mat_d.yz = sample_t'(r_yz[SampleWidth-1:0]);
    mat_d.zx = sample_t'(r_zx[SampleWidth-1:0]);
    mat_d.zy = sample_t'(r_zy[SampleWidth-1:0]);
    mat_d.zz = sample_t'(r_zz[SampleWidth-1:0]);
    clip_d = r_xx[SampleWidth] | r_xy[SampleWidth] | r_xz[SampleWidth]
           | r_yx[SampleWidth] | r_yy[SampleWidth] | r_yz[SampleWidth]
           | r_zx[SampleWidth] | r_zy[SampleWidth] | r_zz[SampleWidth];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mat_q  <= mat_d;
      clip_q <= clip_d;
    end
  end

  assign mat_o     = mat_q;
  assign clipped_o = clip_q;

endmodule

`default_nettype wire

// File: src/quaternion_to_rotation_matrix.sv
// Quaternion to rotation matrix converter, four register stages: input, products, sums, output.
// A request accepted into the input register passes the product, sum and output registers in turn; a stall can hold it.
// Throughput is one request per cycle while stall_i is low; each stage holds only while the stage after it is full.
// Reset clears the stage valid bits only; the data registers are not reset.
// Depends on qrm_pkg, qrm_mult, qrm_sum and qrm_round.
`default_nettype none

module quaternion_to_rotation_matrix (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              valid_i,
  output logic             stall_o,
  input  qrm_pkg::sample_t  q_scalar_i,
  input  qrm_pkg::sample_t  q_x_i,
  input  qrm_pkg::sample_t  q_y_i,
  input  qrm_pkg::sample_t  q_z_i,
  output logic             valid_o,
  input  wire              stall_i,
  output qrm_pkg::sample_t  m_xx_o,
  output qrm_pkg::sample_t  m_xy_o,
  output qrm_pkg::sample_t  m_xz_o,
  output qrm_pkg::sample_t  m_yx_o,
  output qrm_pkg::sample_t  m_yy_o,
  output qrm_pkg::sample_t  m_yz_o,
  output qrm_pkg::sample_t  m_zx_o,
  output qrm_pkg::sample_t  m_zy_o,
  output qrm_pkg::sample_t  m_zz_o,
  output logic             clipped_o
);
  import qrm_pkg::*;

  logic      v1_q, v2_q, v3_q, v4_q;
  logic      v1_d, v2_d, v3_d, v4_d;
  logic      en1, en2, en3, en4;
  quat_t     quat_q;
  prod_set_t prod;
  sum_set_t  sums;
  mat_t      mat;

  assign en4 = !v4_q || !stall_i;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;

  assign v1_d = en1 ? valid_i : v1_q;
  assign v2_d = en2 ? v1_q : v2_q;
  assign v3_d = en3 ? v2_q : v3_q;
  assign v4_d = en4 ? v3_q : v4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= v1_d;
      v2_q <= v2_d;
      v3_q <= v3_d;
      v4_q <= v4_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      quat_q.e0 <= q_scalar_i;
      quat_q.ex <= q_x_i;
      quat_q.ey <= q_y_i;
      quat_q.ez <= q_z_i;
    end
  end

  qrm_mult u_mult (
    .clk_i  (clk_i),
    .en_i   (en2),
    .quat_i (quat_q),
    .prod_o (prod)
  );

  qrm_sum u_sum (
    .clk_i  (clk_i),
    .en_i   (en3),
    .prod_i (prod),
    .sum_o  (sums)
  );

  qrm_round u_round (
    .clk_i     (clk_i),
    .en_i      (en4),
    .sum_i     (sums),
    .mat_o     (mat),
    .clipped_o (clipped_o)
  );

  assign stall_o = !en1;
  assign valid_o = v4_q;
  assign m_xx_o  = mat.xx;
  assign m_xy_o  = mat.xy;
  assign m_xz_o  = mat.xz;
  assign m_yx_o  = mat.yx;
  assign m_yy_o  = mat.yy;
  assign m_yz_o  = mat.yz;
  assign m_zx_o  = mat.zx;
  assign m_zy_o  = mat.zy;
  assign m_zz_o  = mat.zz;

`ifndef SYNTHESIS
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> (v1_q && v2_q && v3_q && v4_q && stall_i))
    else $error("input stalled while the pipeline has a free stage");

  a_accept_enters_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_i && !stall_o) |=> v1_q)
    else $error("accepted request did not reach the input stage");

  a_output_from_sums: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(valid_o) |-> $past(v3_q))
    else $error("output became valid without a request in the sum stage");

  a_no_loss_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && v4_q && stall_i) |=> (v3_q && v4_q))
    else $error("request dropped while the output was stalled");
`endif

endmodule

`default_nettype wire
